FILE: rtl/swdv_pkg.sv
// shared constants, codes and controller/datapath interface types
package swdv_pkg;

  localparam int DEPTH      = 64;
  localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int VAL_W      = 32;
  localparam int OP_W       = 2;
  localparam int ST_W       = 3;
  localparam int IN_DATA_W  = ((VAL_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((VAL_W + 7) / 8) * 8;

  typedef logic [OP_W-1:0] op_t;

  localparam op_t OP_PUSH   = 2'd0;
  localparam op_t OP_DELETE = 2'd1;
  localparam op_t OP_DUMP   = 2'd2;

  typedef enum logic [ST_W-1:0] {
    ST_PUSHED   = 3'd0,
    ST_OVERFLOW = 3'd1,
    ST_DELETED  = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_EMPTY    = 3'd4,
    ST_LISTED   = 3'd5
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic del_step;
    logic del_finish;
    logic dump_rd;
    logic out_resp;
    logic out_list;
  } swdv_cmd_t;

  // datapath to controller
  typedef struct packed {
    op_t  op;
    logic fill_zero;
    logic del_done;
    logic dump_bottom;
    logic out_free;
  } swdv_sts_t;

endpackage

FILE: rtl/swdv_ram.sv
// generic single-port-write, single-port-read ram with registered read
module swdv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/swdv_dp.sv
// datapath: stack ram, fill and scan pointers, result register
module swdv_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [swdv_pkg::OP_W-1:0]           in_tuser,
  input  logic [swdv_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic                                out_tready,
  output logic                                out_tvalid,
  output logic [swdv_pkg::ST_W-1:0]           out_tuser,
  output logic [swdv_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                                out_tlast,
  input  swdv_pkg::swdv_cmd_t                 cmd,
  output swdv_pkg::swdv_sts_t                 sts
);

  localparam int CW = swdv_pkg::CNT_W;
  localparam int AW = swdv_pkg::ADDR_W;
  localparam int VW = swdv_pkg::VAL_W;

  swdv_pkg::op_t     in_op;
  logic [VW-1:0]     in_value;

  logic [CW-1:0]     fill_r, fill_nxt;
  logic [CW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic              pend_r, pend_nxt;
  logic              hit_r, hit_nxt;
  logic [VW-1:0]     value_r, value_nxt;
  swdv_pkg::status_t res_status_r, res_status_nxt;
  logic              out_valid_r, out_valid_nxt;
  swdv_pkg::status_t out_status_r, out_status_nxt;
  logic [VW-1:0]     out_entry_r, out_entry_nxt;
  logic              out_last_r, out_last_nxt;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [VW-1:0]     ram_wdata;
  logic              ram_re;
  logic [VW-1:0]     ram_rdata;
  logic              full;

  assign in_op    = in_tuser;
  assign in_value = in_tdata[VW-1:0];
  assign full     = (fill_r == CW'(swdv_pkg::DEPTH));

  swdv_ram #(
    .WIDTH (VW),
    .DEPTH (swdv_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_ptr_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    fill_nxt       = fill_r;
    rd_ptr_nxt     = rd_ptr_r;
    wr_ptr_nxt     = wr_ptr_r;
    pend_nxt       = pend_r;
    hit_nxt        = hit_r;
    value_nxt      = value_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_entry_nxt  = out_entry_r;
    out_last_nxt   = out_last_r;
    ram_we         = 1'b0;
    ram_waddr      = fill_r[AW-1:0];
    ram_wdata      = in_value;
    ram_re         = 1'b0;

    if (cmd.accept) begin
      value_nxt  = in_value;
      rd_ptr_nxt = '0;
      wr_ptr_nxt = '0;
      hit_nxt    = 1'b0;
      pend_nxt   = 1'b0;
      case (in_op)
        swdv_pkg::OP_PUSH: begin
          if (full) begin
            res_status_nxt = swdv_pkg::ST_OVERFLOW;
          end else begin
            ram_we         = 1'b1;
            fill_nxt       = fill_r + CW'(1);
            res_status_nxt = swdv_pkg::ST_PUSHED;
          end
        end
        swdv_pkg::OP_DELETE: begin
          res_status_nxt = swdv_pkg::ST_EMPTY;
        end
        swdv_pkg::OP_DUMP: begin
          res_status_nxt = swdv_pkg::ST_EMPTY;
          rd_ptr_nxt     = fill_r - CW'(1);
        end
        default: begin
        end
      endcase
    end

    // compaction: read at rd_ptr, keep the previous word at wr_ptr unless it matches
    if (cmd.del_step) begin
      if (rd_ptr_r != fill_r) begin
        ram_re     = 1'b1;
        rd_ptr_nxt = rd_ptr_r + CW'(1);
        pend_nxt   = 1'b1;
      end else begin
        pend_nxt = 1'b0;
      end
      if (pend_r) begin
        if (ram_rdata != value_r) begin
          ram_we     = 1'b1;
          ram_waddr  = wr_ptr_r[AW-1:0];
          ram_wdata  = ram_rdata;
          wr_ptr_nxt = wr_ptr_r + CW'(1);
        end else begin
          hit_nxt = 1'b1;
        end
      end
    end

    if (cmd.del_finish) begin
      fill_nxt       = wr_ptr_r;
      res_status_nxt = hit_r ? swdv_pkg::ST_DELETED : swdv_pkg::ST_NOTFOUND;
    end

    if (cmd.dump_rd) begin
      ram_re = 1'b1;
    end

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_resp) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res_status_r;
      out_entry_nxt  = '0;
      out_last_nxt   = 1'b1;
    end
    if (cmd.out_list) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = swdv_pkg::ST_LISTED;
      out_entry_nxt  = ram_rdata;
      out_last_nxt   = (rd_ptr_r == '0);
      rd_ptr_nxt     = rd_ptr_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_ptr_r     <= rd_ptr_nxt;
    wr_ptr_r     <= wr_ptr_nxt;
    hit_r        <= hit_nxt;
    value_r      <= value_nxt;
    res_status_r <= res_status_nxt;
    out_status_r <= out_status_nxt;
    out_entry_r  <= out_entry_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = swdv_pkg::OUT_DATA_W'(out_entry_r);

  assign sts.op          = in_op;
  assign sts.fill_zero   = (fill_r == '0);
  assign sts.del_done    = (rd_ptr_r == fill_r) && !pend_r;
  assign sts.dump_bottom = (rd_ptr_r == '0);
  assign sts.out_free    = !out_valid_r || out_tready;

endmodule

FILE: rtl/swdv_ctrl.sv
// controller state machine: sequences push, delete scan and dump
module swdv_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  swdv_pkg::swdv_sts_t sts,
  output swdv_pkg::swdv_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_RESP     = 5'b00010,
    S_DEL      = 5'b00100,
    S_DUMP_RD  = 5'b01000,
    S_DUMP_OUT = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          case (sts.op)
            swdv_pkg::OP_PUSH:   state_nxt = S_RESP;
            swdv_pkg::OP_DELETE: state_nxt = sts.fill_zero ? S_RESP : S_DEL;
            swdv_pkg::OP_DUMP:   state_nxt = sts.fill_zero ? S_RESP : S_DUMP_RD;
            default:             state_nxt = S_IDLE;
          endcase
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.out_resp = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_DEL: begin
        cmd.del_step = 1'b1;
        if (sts.del_done) begin
          cmd.del_finish = 1'b1;
          state_nxt      = S_RESP;
        end
      end
      S_DUMP_RD: begin
        cmd.dump_rd = 1'b1;
        state_nxt   = S_DUMP_OUT;
      end
      S_DUMP_OUT: begin
        if (sts.out_free) begin
          cmd.out_list = 1'b1;
          state_nxt    = sts.dump_bottom ? S_IDLE : S_DUMP_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/stack_with_delete_by_value.sv
// top level: bounded stack with push, delete-all-by-value and dump
//
//   channel   direction  tuser (bit 0 up)   tdata (bit 0 up)   tlast
//   in_*      slave      op[1:0]            value[31:0]        -
//   out_*     master     status[2:0]        entry[31:0]        last result of the item
//
// one item at a time; a push or other single-result item goes through the response state to its result.
// a delete scans the stack through the ram read port.
// a dump reads each entry (ram read, then result register), top first, and waits while the output stalls.
// reset empties the stack at once; the stored words need no clearing.
// a stalled result holds in the output register; the next item is taken meanwhile.
module stack_with_delete_by_value (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [swdv_pkg::OP_W-1:0]           in_tuser,   // op
  input  logic [swdv_pkg::IN_DATA_W-1:0]      in_tdata,   // value
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [swdv_pkg::ST_W-1:0]           out_tuser,  // status
  output logic [swdv_pkg::OUT_DATA_W-1:0]     out_tdata,  // entry
  output logic                                out_tlast
);

  swdv_pkg::swdv_cmd_t cmd;
  swdv_pkg::swdv_sts_t sts;

  swdv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  swdv_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

FILE: tb/sv/tb_stack_with_delete_by_value.sv
// testbench for stack_with_delete_by_value: directed table, a fill-to-overflow run, then random traffic
module tb_stack_with_delete_by_value;
  timeunit 1ns;
  timeprecision 1ps;

  localparam swdv_pkg::op_t OP_UNUSED = 2'd3;
  localparam int  ITEM_TARGET = 230;
  localparam int  N_ROWS = 24;

  typedef struct packed {
    swdv_pkg::status_t status;
    logic [31:0]       entry;
    logic              last;
  } result_t;

  typedef struct packed {
    swdv_pkg::op_t     op;
    logic [31:0]       value;
    logic              typed;
    swdv_pkg::status_t status;
  } row_t;

  // typed rows carry a single result whose status is read off directly
  localparam row_t DIR_ROWS [N_ROWS] = '{
    '{swdv_pkg::OP_DUMP,   32'h0000_0000, 1'b1, swdv_pkg::ST_EMPTY},
    '{swdv_pkg::OP_DELETE, 32'h0000_0000, 1'b1, swdv_pkg::ST_EMPTY},
    '{OP_UNUSED,           32'h0000_0000, 1'b0, swdv_pkg::ST_PUSHED},
    '{swdv_pkg::OP_PUSH,   32'h7fff_ffff, 1'b1, swdv_pkg::ST_PUSHED},
    '{swdv_pkg::OP_PUSH,   32'h8000_0000, 1'b1, swdv_pkg::ST_PUSHED},
    '{swdv_pkg::OP_PUSH,   32'h0000_0000, 1'b1, swdv_pkg::ST_PUSHED},
    '{swdv_pkg::OP_PUSH,   32'hffff_ffff, 1'b1, swdv_pkg::ST_PUSHED},
    '{swdv_pkg::OP_PUSH,   32'h0000_0005, 1'b1, swdv_pkg::ST_PUSHED},
    '{swdv_pkg::OP_PUSH,   32'h0000_0005, 1'b1, swdv_pkg::ST_PUSHED},
    '{swdv_pkg::OP_PUSH,   32'h0000_0005, 1'b1, swdv_pkg::ST_PUSHED},
    '{swdv_pkg::OP_PUSH,   32'hffff_ffff, 1'b1, swdv_pkg::ST_PUSHED},
    '{swdv_pkg::OP_DUMP,   32'h0000_0000, 1'b0, swdv_pkg::ST_PUSHED},
    '{swdv_pkg::OP_DELETE, 32'h0000_0005, 1'b0, swdv_pkg::ST_PUSHED},
    '{swdv_pkg::OP_DELETE, 32'h0000_0005, 1'b0, swdv_pkg::ST_PUSHED},
    '{swdv_pkg::OP_DELETE, 32'h8000_0000, 1'b0, swdv_pkg::ST_PUSHED},
    '{OP_UNUSED,           32'hffff_ffff, 1'b0, swdv_pkg::ST_PUSHED},
    '{swdv_pkg::OP_DUMP,   32'hffff_ffff, 1'b0, swdv_pkg::ST_PUSHED},
    '{swdv_pkg::OP_DELETE, 32'hffff_ffff, 1'b0, swdv_pkg::ST_PUSHED},
    '{swdv_pkg::OP_DELETE, 32'h7fff_ffff, 1'b0, swdv_pkg::ST_PUSHED},
    '{swdv_pkg::OP_DELETE, 32'h0000_0000, 1'b0, swdv_pkg::ST_PUSHED},
    '{swdv_pkg::OP_DUMP,   32'h0000_0000, 1'b1, swdv_pkg::ST_EMPTY},
    '{swdv_pkg::OP_DELETE, 32'h0000_0001, 1'b1, swdv_pkg::ST_EMPTY},
    '{swdv_pkg::OP_PUSH,   32'h0000_0001, 1'b1, swdv_pkg::ST_PUSHED},
    '{swdv_pkg::OP_DUMP,   32'h0000_0000, 1'b0, swdv_pkg::ST_PUSHED}
  };

  localparam logic [31:0] VALUE_POOL [8] = '{
    32'h0000_0000, 32'h0000_0001, 32'hffff_ffff, 32'h0000_0005,
    32'h0000_0007, 32'h7fff_ffff, 32'h8000_0000, 32'h5a5a_5a5a
  };

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [swdv_pkg::OP_W-1:0]       in_tuser = '0;
  logic [swdv_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [swdv_pkg::ST_W-1:0]       out_tuser;
  logic [swdv_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                            out_tlast;

  // shadow copy of the stack, bottom at index 0
  logic [31:0] shadow_mem [swdv_pkg::DEPTH];
  int          shadow_fill = 0;

  result_t     pending_results [$];
  result_t     fresh_results [$];
  int          err_cnt = 0;
  int          n_sent = 0;
  bit          src_calm = 1'b0;
  bit          sink_calm = 1'b0;

  stack_with_delete_by_value u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #(20 * 4000000);
    $display("tb_stack_with_delete_by_value: done, errors");
    $finish;
  end

  task automatic flag_error(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("%s", msg);
  endtask

  // mostly short gaps, a few long ones
  function automatic int gap_len(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // applies one transaction to the shadow stack, results land in fresh_results
  task automatic stack_apply(input swdv_pkg::op_t op, input logic [31:0] val);
    int w;
    fresh_results = {};
    case (op)
      swdv_pkg::OP_PUSH: begin
        if (shadow_fill >= swdv_pkg::DEPTH) begin
          fresh_results.push_back('{swdv_pkg::ST_OVERFLOW, 32'd0, 1'b1});
        end else begin
          shadow_mem[shadow_fill] = val;
          shadow_fill++;
          fresh_results.push_back('{swdv_pkg::ST_PUSHED, 32'd0, 1'b1});
        end
      end
      swdv_pkg::OP_DELETE: begin
        if (shadow_fill == 0) begin
          fresh_results.push_back('{swdv_pkg::ST_EMPTY, 32'd0, 1'b1});
        end else begin
          w = 0;
          for (int r = 0; r < shadow_fill; r++) begin
            if (shadow_mem[r] != val) begin
              shadow_mem[w] = shadow_mem[r];
              w++;
            end
          end
          if (w == shadow_fill) begin
            fresh_results.push_back('{swdv_pkg::ST_NOTFOUND, 32'd0, 1'b1});
          end else begin
            shadow_fill = w;
            fresh_results.push_back('{swdv_pkg::ST_DELETED, 32'd0, 1'b1});
          end
        end
      end
      swdv_pkg::OP_DUMP: begin
        if (shadow_fill == 0) begin
          fresh_results.push_back('{swdv_pkg::ST_EMPTY, 32'd0, 1'b1});
        end else begin
          for (int i = shadow_fill - 1; i >= 0; i--)
            fresh_results.push_back('{swdv_pkg::ST_LISTED, shadow_mem[i], (i == 0)});
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_item(input swdv_pkg::op_t op, input logic [31:0] val,
                           input logic typed, input swdv_pkg::status_t typed_status);
    int gap;
    gap = gap_len(src_calm);
    repeat (gap) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= swdv_pkg::IN_DATA_W'(val);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    stack_apply(op, val);
    if (typed) begin
      pending_results.push_back('{typed_status, 32'd0, 1'b1});
    end else begin
      foreach (fresh_results[i]) pending_results.push_back(fresh_results[i]);
    end
    if (op != OP_UNUSED) n_sent++;
  endtask

  function automatic logic [31:0] pick_value(input bit for_delete);
    int r;
    r = $urandom_range(0, 99);
    if (for_delete && shadow_fill > 0 && r < 40)
      return shadow_mem[$urandom_range(0, shadow_fill - 1)];
    if (r < 75) return VALUE_POOL[$urandom_range(0, 7)];
    return $urandom();
  endfunction

  // result side: check each transaction, stall at random
  initial begin
    result_t     want;
    logic [2:0]  got_status;
    logic [31:0] got_entry;
    int          stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        got_status = out_tuser;
        got_entry  = out_tdata[31:0];
        if (pending_results.size() == 0) begin
          flag_error($sformatf("unexpected result: status %0d entry %h last %b",
                               got_status, got_entry, out_tlast));
        end else begin
          want = pending_results.pop_front();
          if (got_status !== want.status || got_entry !== want.entry ||
              out_tlast !== want.last)
            flag_error($sformatf("mismatch: want status %0d entry %h last %b, got %0d %h %b",
                                 want.status, want.entry, want.last,
                                 got_status, got_entry, out_tlast));
        end
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        if (!sink_calm && $urandom_range(0, 99) < 30) stall_left = gap_len(1'b0);
      end
      if ($urandom_range(0, 299) == 0) sink_calm = ~sink_calm;
    end
  end

  initial begin
    int            r;
    int            push_w;
    swdv_pkg::op_t op;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIR_ROWS[i])
      send_item(DIR_ROWS[i].op, DIR_ROWS[i].value, DIR_ROWS[i].typed, DIR_ROWS[i].status);

    // fill to the top, run into overflow, list everything, then thin it out
    src_calm = 1'b1;
    while (shadow_fill < swdv_pkg::DEPTH)
      send_item(swdv_pkg::OP_PUSH, pick_value(1'b0), 1'b0, swdv_pkg::ST_PUSHED);
    src_calm = 1'b0;
    repeat (3) send_item(swdv_pkg::OP_PUSH, $urandom(), 1'b0, swdv_pkg::ST_PUSHED);
    send_item(swdv_pkg::OP_DUMP, $urandom(), 1'b0, swdv_pkg::ST_PUSHED);
    repeat (6) send_item(swdv_pkg::OP_DELETE, pick_value(1'b1), 1'b0, swdv_pkg::ST_PUSHED);
    send_item(swdv_pkg::OP_DUMP, $urandom(), 1'b0, swdv_pkg::ST_PUSHED);

    push_w = 50;
    while (n_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 29) == 0) begin
        push_w = 30 + 20 * $urandom_range(0, 2);
        src_calm = ($urandom_range(0, 3) == 0);
      end
      r = $urandom_range(0, 99);
      if (r < 4) op = OP_UNUSED;
      else if (r < 4 + push_w) op = swdv_pkg::OP_PUSH;
      else if (r < 4 + push_w + (96 - push_w) * 6 / 10) op = swdv_pkg::OP_DELETE;
      else op = swdv_pkg::OP_DUMP;
      send_item(op, pick_value(op == swdv_pkg::OP_DELETE), 1'b0, swdv_pkg::ST_PUSHED);
    end
    in_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    // room for any stray result from a long delete scan or dump
    repeat (swdv_pkg::DEPTH * 2 + 80) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb_stack_with_delete_by_value: done, clean");
    end else begin
      $display("tb_stack_with_delete_by_value: done, errors");
    end
    $finish;
  end

endmodule
